// File: design/mfba_pkg.sv
// ---------------------------------------------------------------------------
// mfba_pkg
// Shared types and constants of the max-flow search block.
// ---------------------------------------------------------------------------
package mfba_pkg;

  localparam int unsigned NODE_W  = 8;
  localparam int unsigned NODES   = 256;
  localparam int unsigned PTR_W   = 9;   // holds 0 .. NODES
  localparam int unsigned ROUND_W = 11;
  localparam int unsigned CAP_W   = 32;
  localparam logic [CAP_W-1:0] CAP_MAX = '1;

  localparam logic CFG_SOURCE = 1'b0;
  localparam logic CFG_SINK   = 1'b1;

  // one arc: forward edge 2k (tail -> head) and reverse edge 2k+1
  typedef struct packed {
    logic [NODE_W-1:0] head;
    logic [NODE_W-1:0] tail;
    logic [CAP_W-1:0]  fwd;
    logic [CAP_W-1:0]  rev;
  } row_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BFS_INIT,
    S_DEQ,
    S_DEQ_WAIT,
    S_SCAN,
    S_EVAL,
    S_VCHK,
    S_AUG_STEP,
    S_AUG_BE,
    S_AUG_ROW,
    S_DONE
  } state_e;

endpackage

// File: design/max_flow_bfs_augment.sv
// ---------------------------------------------------------------------------
// max_flow_bfs_augment
// Edmonds-Karp maximum flow over a graph loaded one arc per word.
// ---------------------------------------------------------------------------
// Arcs load at one word per cycle while busy is low; the block stays ready
// after every arc except the one marked last_arc. After that arc busy rises
// and the search runs from the stored graph: each round scans every stored
// edge for every dequeued node, checks the head of every edge out of that
// node with residual left, and each augmenting path is walked twice, once
// for its bottleneck and once to update the residuals. The edge scan through
// the single-port arc memory sets the search time. The result shows on
// done_o for one cycle only and cannot be stalled; the graph is then cleared
// and busy falls. Arcs beyond ARCS are dropped and reported on
// edge_overflow_o.
module max_flow_bfs_augment #(
  parameter int unsigned ARCS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mfba_pkg::NODE_W-1:0]   cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic [mfba_pkg::NODE_W-1:0]   tail_node_i,
  input  logic [mfba_pkg::NODE_W-1:0]   head_node_i,
  input  logic [mfba_pkg::CAP_W-1:0]    arc_capacity_i,
  input  logic                          last_arc_i,
  output logic                          done_o,
  output logic [mfba_pkg::CAP_W-1:0]    max_flow_o,
  output logic                          flow_saturated_o,
  output logic                          edge_overflow_o
);

  localparam int unsigned AW = (ARCS > 1) ? $clog2(ARCS) : 1;
  localparam int unsigned CW = $clog2(ARCS + 1);
  localparam int unsigned EW = AW + 1;
  localparam int unsigned NW = mfba_pkg::NODE_W;
  localparam int unsigned PW = mfba_pkg::PTR_W;
  localparam int unsigned RW = mfba_pkg::ROUND_W;
  localparam int unsigned KW = mfba_pkg::CAP_W;

  mfba_pkg::state_e state_q, state_d;

  logic [NW-1:0]    src_q, snk_q;
  logic [CW-1:0]    pair_cnt_q, pair_cnt_d;
  logic [KW-1:0]    flow_q, flow_d;
  logic             sat_q, sat_d, ovf_q, ovf_d;
  logic [RW-1:0]    round_q, round_d;
  logic [PW-1:0]    rptr_q, rptr_d, wptr_q, wptr_d;
  logic [NW-1:0]    u_q, u_d, v_q, v_d;
  logic [CW:0]      e_q, e_d;
  logic [PW-1:0]    steps_q, steps_d;
  logic             pass_q, pass_d;
  logic [KW-1:0]    bneck_q, bneck_d;
  logic [mfba_pkg::NODES-1:0] valid_q, valid_d;

  // memories
  mfba_pkg::row_t   row_mem [ARCS];
  logic [RW-1:0]    stamp_mem [mfba_pkg::NODES];
  logic [EW-1:0]    back_mem [mfba_pkg::NODES];
  logic [NW-1:0]    queue_mem [mfba_pkg::NODES];

  logic             row_we;
  logic [AW-1:0]    row_addr;
  mfba_pkg::row_t   row_wd, row_rd_q;
  logic             stamp_we;
  logic [NW-1:0]    stamp_addr;
  logic [RW-1:0]    stamp_rd_q;
  logic             back_we;
  logic [NW-1:0]    back_addr;
  logic [EW-1:0]    back_rd_q;
  logic             queue_we;
  logic [NW-1:0]    queue_waddr, queue_raddr;
  logic [NW-1:0]    queue_rd_q;

  always_ff @(posedge clk_i) begin
    if (row_we) begin
      row_mem[row_addr] <= row_wd;
    end
    row_rd_q <= row_mem[row_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stamp_we) begin
      stamp_mem[stamp_addr] <= round_d;
    end
    stamp_rd_q <= stamp_mem[stamp_addr];
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_addr] <= e_q[EW-1:0];
    end
    back_rd_q <= back_mem[back_addr];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) begin
      queue_mem[queue_waddr] <= v_d;
    end
    queue_rd_q <= queue_mem[queue_raddr];
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= '0;
      snk_q <= NW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mfba_pkg::CFG_SOURCE: src_q <= cfg_wdata_i;
        mfba_pkg::CFG_SINK:   snk_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mfba_pkg::S_IDLE;
      pair_cnt_q <= '0;
      flow_q     <= '0;
      sat_q      <= 1'b0;
      ovf_q      <= 1'b0;
      round_q    <= '0;
      rptr_q     <= '0;
      wptr_q     <= '0;
      u_q        <= '0;
      v_q        <= '0;
      e_q        <= '0;
      steps_q    <= '0;
      pass_q     <= 1'b0;
      bneck_q    <= '0;
      valid_q    <= '0;
    end else begin
      state_q    <= state_d;
      pair_cnt_q <= pair_cnt_d;
      flow_q     <= flow_d;
      sat_q      <= sat_d;
      ovf_q      <= ovf_d;
      round_q    <= round_d;
      rptr_q     <= rptr_d;
      wptr_q     <= wptr_d;
      u_q        <= u_d;
      v_q        <= v_d;
      e_q        <= e_d;
      steps_q    <= steps_d;
      pass_q     <= pass_d;
      bneck_q    <= bneck_d;
      valid_q    <= valid_d;
    end
  end

  // edge view of the row last read, selected by edge parity
  logic [NW-1:0] edge_tail, edge_head;
  logic [KW-1:0] edge_res;
  logic [RW-1:0] round_inc;
  logic [KW:0]   flow_sum;

  always_comb begin
    edge_tail = e_q[0] ? row_rd_q.head : row_rd_q.tail;
    edge_head = e_q[0] ? row_rd_q.tail : row_rd_q.head;
    edge_res  = e_q[0] ? row_rd_q.rev  : row_rd_q.fwd;
    round_inc = round_q + RW'(1);
    flow_sum  = {1'b0, flow_q} + {1'b0, bneck_q};
  end

  always_comb begin
    state_d    = state_q;
    pair_cnt_d = pair_cnt_q;
    flow_d     = flow_q;
    sat_d      = sat_q;
    ovf_d      = ovf_q;
    round_d    = round_q;
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    u_d        = u_q;
    v_d        = v_q;
    e_d        = e_q;
    steps_d    = steps_q;
    pass_d     = pass_q;
    bneck_d    = bneck_q;
    valid_d    = valid_q;

    row_we      = 1'b0;
    row_addr    = e_q[AW:1];
    row_wd      = row_rd_q;
    stamp_we    = 1'b0;
    stamp_addr  = v_q;
    back_we     = 1'b0;
    back_addr   = v_q;
    queue_we    = 1'b0;
    queue_waddr = wptr_q[NW-1:0];
    queue_raddr = rptr_q[NW-1:0];

    unique case (state_q)
      mfba_pkg::S_IDLE: begin
        row_addr = pair_cnt_q[AW-1:0];
        row_wd   = '{head: head_node_i, tail: tail_node_i, fwd: arc_capacity_i, rev: '0};
        if (start) begin
          if (pair_cnt_q < CW'(ARCS)) begin
            row_we     = 1'b1;
            pair_cnt_d = pair_cnt_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (last_arc_i) begin
            flow_d  = '0;
            sat_d   = 1'b0;
            state_d = (src_q == snk_q) ? mfba_pkg::S_DONE : mfba_pkg::S_BFS_INIT;
          end
        end
      end

      mfba_pkg::S_BFS_INIT: begin
        // stamp wrap: drop every visit mark and restart at round one
        if (round_inc == '0) begin
          round_d = RW'(1);
          valid_d = '0;
        end else begin
          round_d = round_inc;
        end
        v_d             = src_q;
        stamp_addr      = src_q;
        stamp_we        = 1'b1;
        valid_d[src_q]  = 1'b1;
        queue_waddr     = '0;
        queue_we        = 1'b1;
        rptr_d          = '0;
        wptr_d          = PW'(1);
        state_d         = mfba_pkg::S_DEQ;
      end

      mfba_pkg::S_DEQ: begin
        if (rptr_q < wptr_q) begin
          rptr_d  = rptr_q + PW'(1);
          state_d = mfba_pkg::S_DEQ_WAIT;
        end else begin
          state_d = mfba_pkg::S_DONE;
        end
      end

      mfba_pkg::S_DEQ_WAIT: begin
        u_d     = queue_rd_q;
        e_d     = '0;
        state_d = mfba_pkg::S_SCAN;
      end

      mfba_pkg::S_SCAN: begin
        if (e_q < {pair_cnt_q, 1'b0}) begin
          state_d = mfba_pkg::S_EVAL;
        end else begin
          state_d = mfba_pkg::S_DEQ;
        end
      end

      mfba_pkg::S_EVAL: begin
        if (edge_tail == u_q && edge_res != '0) begin
          v_d        = edge_head;
          stamp_addr = edge_head;
          state_d    = mfba_pkg::S_VCHK;
        end else begin
          e_d     = e_q + (CW+1)'(1);
          state_d = mfba_pkg::S_SCAN;
        end
      end

      mfba_pkg::S_VCHK: begin
        e_d     = e_q + (CW+1)'(1);
        state_d = mfba_pkg::S_SCAN;
        if (!(valid_q[v_q] && stamp_rd_q == round_q)) begin
          stamp_we       = 1'b1;
          valid_d[v_q]   = 1'b1;
          back_we        = 1'b1;
          if (v_q == snk_q) begin
            v_d     = snk_q;
            steps_d = '0;
            pass_d  = 1'b0;
            bneck_d = mfba_pkg::CAP_MAX;
            state_d = mfba_pkg::S_AUG_STEP;
          end else if (wptr_q < PW'(mfba_pkg::NODES)) begin
            queue_we = 1'b1;
            wptr_d   = wptr_q + PW'(1);
          end
        end
      end

      mfba_pkg::S_AUG_STEP: begin
        if (v_q == src_q || steps_q == PW'(mfba_pkg::NODES)) begin
          if (!pass_q) begin
            pass_d  = 1'b1;
            v_d     = snk_q;
            steps_d = '0;
          end else begin
            if (flow_sum[KW]) begin
              flow_d = mfba_pkg::CAP_MAX;
              sat_d  = 1'b1;
            end else begin
              flow_d = flow_sum[KW-1:0];
            end
            state_d = mfba_pkg::S_BFS_INIT;
          end
        end else begin
          state_d = mfba_pkg::S_AUG_BE;
        end
      end

      mfba_pkg::S_AUG_BE: begin
        e_d      = (CW+1)'(back_rd_q);
        row_addr = back_rd_q[AW:1];
        state_d  = mfba_pkg::S_AUG_ROW;
      end

      mfba_pkg::S_AUG_ROW: begin
        if (!pass_q) begin
          if (edge_res < bneck_q) begin
            bneck_d = edge_res;
          end
        end else begin
          row_we = 1'b1;
          if (e_q[0]) begin
            row_wd.rev = row_rd_q.rev - bneck_q;
            row_wd.fwd = row_rd_q.fwd + bneck_q;
          end else begin
            row_wd.fwd = row_rd_q.fwd - bneck_q;
            row_wd.rev = row_rd_q.rev + bneck_q;
          end
        end
        // walk back to the tail of this edge
        v_d     = edge_tail;
        steps_d = steps_q + PW'(1);
        state_d = mfba_pkg::S_AUG_STEP;
      end

      mfba_pkg::S_DONE: begin
        pair_cnt_d = '0;
        flow_d     = '0;
        sat_d      = 1'b0;
        ovf_d      = 1'b0;
        state_d    = mfba_pkg::S_IDLE;
      end

      default: state_d = mfba_pkg::S_IDLE;
    endcase
  end

  assign busy             = (state_q != mfba_pkg::S_IDLE);
  assign done_o           = (state_q == mfba_pkg::S_DONE);
  assign max_flow_o       = flow_q;
  assign flow_saturated_o = sat_q;
  assign edge_overflow_o  = ovf_q;

endmodule

// File: design/mfba_checker.sv
// ---------------------------------------------------------------------------
// mfba_checker
// Port-level checks of the max-flow block, bound to the top level.
// ---------------------------------------------------------------------------
module mfba_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic last_arc_i,
  input logic done_o
);

  // a plain arc keeps the block ready
  a_plain_arc_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !last_arc_i |=> !busy)
    else $error("block went busy after a plain arc");

  a_last_arc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && last_arc_i |=> busy)
    else $error("last arc did not start the search");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result word while idle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("result word not followed by idle");

endmodule

bind max_flow_bfs_augment mfba_checker u_mfba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .last_arc_i (last_arc_i),
  .done_o     (done_o)
);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Loads random and directed graphs one arc per word, predicts the maximum
// flow of each graph with its own breadth-first augmenting search and
// compares every result word field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned NODES = mfba_pkg::NODES;
  localparam int unsigned EDGE_SLOTS = 2048;
  localparam int unsigned CYCLE_LIMIT = 30000000;
  localparam int unsigned EXP_DEPTH = 16;

  typedef struct {
    logic [31:0] flow;
    logic        sat;
    logic        ovf;
  } flow_word_t;

  class flow_scoreboard;
    logic [7:0]  src_node;
    logic [7:0]  snk_node;
    logic [31:0] resid[EDGE_SLOTS];
    logic [7:0]  ehead[EDGE_SLOTS];
    int unsigned edge_cnt;
    logic [10:0] stamp[NODES];
    logic [10:0] round_no;
    int unsigned back[NODES];
    int unsigned bfs_q[NODES];
    int unsigned adj_first[NODES+1];
    int unsigned adj_fill[NODES];
    int unsigned adj_edge[EDGE_SLOTS];
    logic        drop_flag;
    logic [31:0] total;
    logic        sat_flag;
    flow_word_t  exp_ring[EXP_DEPTH];
    int unsigned exp_rd;
    int unsigned exp_wr;
    int          mismatches;

    function new();
      src_node = '0;
      snk_node = 8'd1;
      edge_cnt = 0;
      round_no = '0;
      drop_flag = 1'b0;
      exp_rd = 0;
      exp_wr = 0;
      mismatches = 0;
      foreach (stamp[i]) stamp[i] = '0;
    endfunction

    function int unsigned pending();
      return exp_wr - exp_rd;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == mfba_pkg::CFG_SOURCE) src_node = val;
      else snk_node = val;
    endfunction

    function void build_adjacency();
      int unsigned u;
      foreach (adj_first[i]) adj_first[i] = 0;
      for (int unsigned e = 0; e < edge_cnt; e++) adj_first[ehead[e ^ 1] + 1]++;
      for (int n = 0; n < NODES; n++) adj_first[n+1] += adj_first[n];
      for (int n = 0; n < NODES; n++) adj_fill[n] = adj_first[n];
      for (int unsigned e = 0; e < edge_cnt; e++) begin
        u = 32'(ehead[e ^ 1]);
        adj_edge[adj_fill[u]] = e;
        adj_fill[u]++;
      end
    endfunction

    function bit find_path();
      int unsigned rp, wp, u, e, v;
      round_no = round_no + 11'd1;
      if (round_no == '0) begin
        foreach (stamp[i]) stamp[i] = '0;
        round_no = 11'd1;
      end
      rp = 0;
      wp = 1;
      bfs_q[0] = 32'(src_node);
      stamp[src_node] = round_no;
      while (rp < wp && rp < NODES) begin
        u = bfs_q[rp];
        rp++;
        for (int unsigned k = adj_first[u]; k < adj_first[u+1]; k++) begin
          e = adj_edge[k];
          if (resid[e] == 0) continue;
          v = 32'(ehead[e]);
          if (stamp[v] == round_no) continue;
          stamp[v] = round_no;
          back[v] = e;
          if (v == snk_node) return 1;
          if (wp < NODES) begin
            bfs_q[wp] = v;
            wp++;
          end
        end
      end
      return 0;
    endfunction

    function void push_flow();
      logic [31:0] bneck;
      int unsigned v, e, steps;
      bneck = '1;
      v = 32'(snk_node);
      steps = 0;
      while (v != src_node && steps < NODES) begin
        e = back[v];
        if (resid[e] < bneck) bneck = resid[e];
        v = 32'(ehead[e ^ 1]);
        steps++;
      end
      v = 32'(snk_node);
      steps = 0;
      while (v != src_node && steps < NODES) begin
        e = back[v];
        resid[e] -= bneck;
        resid[e ^ 1] += bneck;
        v = 32'(ehead[e ^ 1]);
        steps++;
      end
      if (total > 32'hFFFF_FFFF - bneck) begin
        total = '1;
        sat_flag = 1'b1;
      end else begin
        total += bneck;
      end
    endfunction

    // called for every accepted arc word
    function void note_arc(logic [7:0] t, logic [7:0] h, logic [31:0] c, logic l);
      flow_word_t w;
      if (edge_cnt + 2 <= EDGE_SLOTS) begin
        ehead[edge_cnt] = h;
        resid[edge_cnt] = c;
        ehead[edge_cnt+1] = t;
        resid[edge_cnt+1] = '0;
        edge_cnt += 2;
      end else begin
        drop_flag = 1'b1;
      end
      if (!l) return;
      total = '0;
      sat_flag = 1'b0;
      if (src_node != snk_node) begin
        build_adjacency();
        while (find_path()) push_flow();
      end
      w.flow = total;
      w.sat = sat_flag;
      w.ovf = drop_flag;
      exp_ring[exp_wr % EXP_DEPTH] = w;
      exp_wr++;
      edge_cnt = 0;
      drop_flag = 1'b0;
    endfunction

    function void check_result(logic [31:0] flow, logic sat, logic ovf);
      flow_word_t w;
      if (pending() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: flow %h sat %b ovf %b", flow, sat, ovf);
        return;
      end
      w = exp_ring[exp_rd % EXP_DEPTH];
      exp_rd++;
      if (flow !== w.flow || sat !== w.sat || ovf !== w.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp flow %h sat %b ovf %b, got flow %h sat %b ovf %b",
                   w.flow, w.sat, w.ovf, flow, sat, ovf);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = mfba_pkg::CFG_SOURCE;
  logic [7:0]  cfg_wdata_i = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [7:0]  tail_node_i = '0;
  logic [7:0]  head_node_i = '0;
  logic [31:0] arc_capacity_i = '0;
  logic        last_arc_i = 1'b0;
  logic        done_o;
  logic [31:0] max_flow_o;
  logic        flow_saturated_o;
  logic        edge_overflow_o;

  flow_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned arcs_sent = 0;
  int unsigned burst_left = 0;

  max_flow_bfs_augment dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(max_flow_o, flow_saturated_o, edge_overflow_o);
  end

  task automatic send_arc(logic [7:0] t, logic [7:0] h, logic [31:0] c, logic l);
    if (burst_left == 0) begin
      start = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    start = 1'b1;
    tail_node_i = t;
    head_node_i = h;
    arc_capacity_i = c;
    last_arc_i = l;
    do @(posedge clk_i); while (busy);
    sb.note_arc(t, h, c, l);
    arcs_sent++;
    burst_left--;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic logic [7:0] pick_node(bit wide);
    if (wide || $urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] pick_cap();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  task automatic random_config();
    case ($urandom_range(0, 5))
      0: begin
        write_reg(mfba_pkg::CFG_SOURCE, 8'd255);
        write_reg(mfba_pkg::CFG_SINK, 8'd0);
      end
      1: begin
        write_reg(mfba_pkg::CFG_SOURCE, 8'd3);
        write_reg(mfba_pkg::CFG_SINK, 8'd3);
      end
      default: begin
        write_reg(mfba_pkg::CFG_SOURCE, pick_node(1'b0));
        write_reg(mfba_pkg::CFG_SINK, pick_node(1'b0));
      end
    endcase
  endtask

  initial begin
    int unsigned n_arcs;
    bit wide;
    logic [7:0] s, k;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset registers: source 0, sink 1
    send_arc(8'd0, 8'd1, 32'd5, 1'b1);
    drain();
    // two full arcs saturate the sum
    send_arc(8'd0, 8'd1, '1, 1'b0);
    send_arc(8'd0, 8'd1, '1, 1'b1);
    drain();
    // source equal to sink
    write_reg(mfba_pkg::CFG_SINK, 8'd0);
    send_arc(8'd0, 8'd0, 32'd7, 1'b0);
    send_arc(8'd0, 8'd1, 32'd7, 1'b1);
    drain();
    // extreme nodes, self loop, zero capacity, back arc
    write_reg(mfba_pkg::CFG_SOURCE, 8'd255);
    send_arc(8'd255, 8'd128, '1, 1'b0);
    send_arc(8'd128, 8'd0, 32'h8000_0000, 1'b0);
    send_arc(8'd255, 8'd0, 32'd0, 1'b0);
    send_arc(8'd128, 8'd128, 32'd9, 1'b0);
    send_arc(8'd127, 8'd127, 32'h7FFF_FFFF, 1'b0);
    send_arc(8'd0, 8'd255, 32'd1, 1'b1);
    drain();
    // arc store overflow, mostly zero capacity to keep the search short
    write_reg(mfba_pkg::CFG_SOURCE, 8'd0);
    write_reg(mfba_pkg::CFG_SINK, 8'd7);
    for (int i = 0; i < 1030; i++)
      send_arc(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
               ($urandom_range(0, 99) == 0) ? $urandom_range(1, 50) : 32'd0, i == 1029);
    drain();

    while (arcs_sent < 1650) begin
      if ($urandom_range(0, 3) == 0) random_config();
      n_arcs = $urandom_range(1, 12);
      wide = ($urandom_range(0, 9) == 0);
      s = sb.src_node;
      k = sb.snk_node;
      for (int i = 0; i < n_arcs; i++) begin
        // bias toward arcs leaving the source or entering the sink
        case ($urandom_range(0, 3))
          0: send_arc(s, pick_node(wide), pick_cap(), i == n_arcs - 1);
          1: send_arc(pick_node(wide), k, pick_cap(), i == n_arcs - 1);
          default: send_arc(pick_node(wide), pick_node(wide), pick_cap(), i == n_arcs - 1);
        endcase
      end
      drain();
    end

    repeat (20) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
